// File: rtl/core/bps_pkg.sv
// Package for the bitmap priority task scheduler core.
// Holds sizes, function and error codes, and the shared item, result and state types.
// No dependencies.
`default_nettype none
package bps_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int DELAY_BITS = 16;
  localparam int SLOT_W     = 4;
  localparam int FUNC_W     = 3;
  localparam int ERR_W      = 3;
  localparam int TOTAL_W    = $clog2(NUM_SLOTS + 1);

  localparam logic [SLOT_W-1:0] IDLE_SLOT = SLOT_W'(NUM_SLOTS - 1);

  localparam logic [FUNC_W-1:0] FN_INIT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELAY = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RUN   = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_SLOT  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_START = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TAKEN     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NO_READY  = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [SLOT_W-1:0]     task_slot;
    logic [DELAY_BITS-1:0] delay_ticks;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    next_task;
    logic                 switch_request;
    logic [NUM_SLOTS-1:0] ready_mask;
    logic [NUM_SLOTS-1:0] blocked_mask;
    logic [ERR_W-1:0]     error_code;
  } result_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]                 ready;
    logic [NUM_SLOTS-1:0]                 blocked;
    logic [NUM_SLOTS-1:0]                 used;
    logic [NUM_SLOTS-1:0][DELAY_BITS-1:0] cnt;
    logic [TOTAL_W-1:0]                   total;
    logic [SLOT_W-1:0]                    running_slot;
    logic                                 running_valid;
    logic                                 started;
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/bps_if.sv
// Valid/ready channel interfaces for the scheduler core.
// Payload widths come from bps_pkg.
`default_nettype none
interface bps_in_if;
  logic                           valid;
  logic                           ready;
  logic [bps_pkg::FUNC_W-1:0]     func;
  logic [bps_pkg::SLOT_W-1:0]     task_slot;
  logic [bps_pkg::DELAY_BITS-1:0] delay_ticks;

  modport source (output valid, func, task_slot, delay_ticks, input ready);
  modport sink (input valid, func, task_slot, delay_ticks, output ready);
endinterface

interface bps_out_if;
  logic                          valid;
  logic                          ready;
  logic [bps_pkg::SLOT_W-1:0]    next_task;
  logic                          switch_request;
  logic [bps_pkg::NUM_SLOTS-1:0] ready_mask;
  logic [bps_pkg::NUM_SLOTS-1:0] blocked_mask;
  logic [bps_pkg::ERR_W-1:0]     error_code;

  modport source (output valid, next_task, switch_request, ready_mask, blocked_mask,
                  error_code, input ready);
  modport sink (input valid, next_task, switch_request, ready_mask, blocked_mask,
                error_code, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bps_prio_enc.sv
// Find-first-set encoder: lowest set bit of the ready mask.
// Depends on bps_pkg.
`default_nettype none
module bps_prio_enc (
  input  wire logic [bps_pkg::NUM_SLOTS-1:0] mask,
  output logic                               found,
  output logic [bps_pkg::SLOT_W-1:0]         idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = bps_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        found = 1'b1;
        idx   = bps_pkg::SLOT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bps_step.sv
// Next-state and result logic for one scheduler transaction.
// Depends on bps_pkg and bps_prio_enc.
`default_nettype none
module bps_step (
  input  wire bps_pkg::state_t  st,
  input  wire bps_pkg::item_t   item,
  output bps_pkg::state_t       st_nxt,
  output bps_pkg::result_t      res
);

  logic [bps_pkg::NUM_SLOTS-1:0] rdy_c;
  logic                          found;
  logic [bps_pkg::SLOT_W-1:0]    pick;
  logic [bps_pkg::NUM_SLOTS-1:0] woke;
  logic [bps_pkg::NUM_SLOTS-1:0][bps_pkg::DELAY_BITS-1:0] cnt_dec;
  logic [bps_pkg::NUM_SLOTS-1:0] nr;
  logic                          do_add;
  logic                          add_started;
  logic [bps_pkg::SLOT_W-1:0]    add_s;
  logic                          do_choose;
  logic [bps_pkg::ERR_W-1:0]     err;

  bps_prio_enc u_enc (
    .mask  (rdy_c),
    .found (found),
    .idx   (pick)
  );

  always_comb begin
    for (int i = 0; i < bps_pkg::NUM_SLOTS; i++) begin
      cnt_dec[i] = st.cnt[i] - bps_pkg::DELAY_BITS'(1);
      woke[i]    = st.blocked[i] && (cnt_dec[i] == '0);
    end
    nr = st.ready & ~(bps_pkg::NUM_SLOTS'(1) << st.running_slot);

    do_add      = 1'b0;
    add_started = st.started;
    add_s       = item.task_slot;
    do_choose   = 1'b0;
    rdy_c       = st.ready;
    case (item.func)
      bps_pkg::FN_INIT: begin
        do_add      = 1'b1;
        add_started = 1'b1;
        add_s       = bps_pkg::IDLE_SLOT;
      end
      bps_pkg::FN_ADD: begin
        do_add = 1'b1;
      end
      bps_pkg::FN_DELAY: begin
        rdy_c = nr;
      end
      bps_pkg::FN_TICK: begin
        rdy_c     = st.ready | woke;
        do_choose = 1'b1;
      end
      bps_pkg::FN_RUN: begin
        do_choose = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt = st;
    err    = bps_pkg::ERR_OK;
    res    = '0;
    res.next_task = st.running_slot;

    if (do_add) begin
      if (int'(add_s) >= bps_pkg::NUM_SLOTS) begin
        err = bps_pkg::ERR_BAD_SLOT;
      end else if (!add_started) begin
        err = bps_pkg::ERR_NOT_START;
      end else if (st.total >= bps_pkg::TOTAL_W'(bps_pkg::NUM_SLOTS - 1)) begin
        err = bps_pkg::ERR_TOO_MANY;
      end else if (st.used[add_s]) begin
        err = bps_pkg::ERR_TAKEN;
      end else begin
        st_nxt.used[add_s]  = 1'b1;
        st_nxt.ready[add_s] = 1'b1;
        st_nxt.cnt[add_s]   = '0;
        st_nxt.total        = st.total + bps_pkg::TOTAL_W'(1);
        st_nxt.started      = add_started;
      end
    end

    if (item.func == bps_pkg::FN_DELAY) begin
      if (!st.started || !st.running_valid) begin
        err = bps_pkg::ERR_NOT_START;
      end else if (!nr[bps_pkg::IDLE_SLOT]) begin
        err = bps_pkg::ERR_NO_READY;
      end else begin
        st_nxt.ready                    = nr;
        st_nxt.blocked[st.running_slot] = 1'b1;
        st_nxt.cnt[st.running_slot]     = item.delay_ticks;
        if (found) begin
          res.next_task         = pick;
          res.switch_request    = !st.running_valid || (st.running_slot != pick);
          st_nxt.running_slot   = pick;
          st_nxt.running_valid  = 1'b1;
        end else begin
          err = bps_pkg::ERR_NO_READY;
        end
      end
    end

    if (item.func == bps_pkg::FN_TICK) begin
      for (int i = 0; i < bps_pkg::NUM_SLOTS; i++) begin
        if (st.blocked[i]) begin
          st_nxt.cnt[i] = cnt_dec[i];
        end
      end
      st_nxt.ready   = st.ready | woke;
      st_nxt.blocked = st.blocked & ~woke;
    end

    if (do_choose) begin
      if (found) begin
        res.next_task        = pick;
        res.switch_request   = !st.running_valid || (st.running_slot != pick);
        st_nxt.running_slot  = pick;
        st_nxt.running_valid = 1'b1;
      end else begin
        err = bps_pkg::ERR_NO_READY;
      end
    end

    res.ready_mask   = st_nxt.ready;
    res.blocked_mask = st_nxt.blocked;
    res.error_code   = err;
  end

endmodule
`default_nettype wire

// File: rtl/core/bitmap_priority_task_scheduler_core.sv
// Bitmap priority task scheduler core: input register, one-pass step logic, result register.
// The accepted transaction is held in the input register, its result then in the result register.
// Throughput: one transaction per cycle while the result channel is not stalled.
// Reset (rst_n low, synchronous): both stages empty, all scheduler state cleared.
// Depends on bps_pkg, bps_if and bps_step.
`default_nettype none
module bitmap_priority_task_scheduler_core (
  input  wire logic clk,
  input  wire logic rst_n,
  bps_in_if.sink    in_ch,
  bps_out_if.source out_ch
);

  logic             s1_v_r, s1_v_nxt;
  bps_pkg::item_t   s1_item_r;
  bps_pkg::state_t  st_r, st_nxt;
  logic             out_v_r, out_v_nxt;
  bps_pkg::result_t out_res_r;
  bps_pkg::result_t res_c;
  logic             advance;
  logic             in_fire;

  bps_step u_step (
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res_c)
  );

  assign advance      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : s1_v_r);
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.func        <= in_ch.func;
      s1_item_r.task_slot   <= in_ch.task_slot;
      s1_item_r.delay_ticks <= in_ch.delay_ticks;
    end
    if (advance) begin
      out_res_r <= res_c;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.next_task      = out_res_r.next_task;
  assign out_ch.switch_request = out_res_r.switch_request;
  assign out_ch.ready_mask     = out_res_r.ready_mask;
  assign out_ch.blocked_mask   = out_res_r.blocked_mask;
  assign out_ch.error_code     = out_res_r.error_code;

endmodule
`default_nettype wire

// File: rtl/core/bps_checker.sv
// Port-level checks for the scheduler core, attached by bind.
// Depends on bps_pkg and the top level's channel ports.
`default_nettype none
module bps_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bps_pkg::SLOT_W-1:0]    out_next_task,
  input wire logic                          out_switch_request,
  input wire logic [bps_pkg::NUM_SLOTS-1:0] out_ready_mask,
  input wire logic [bps_pkg::NUM_SLOTS-1:0] out_blocked_mask,
  input wire logic [bps_pkg::ERR_W-1:0]     out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_task)
      && $stable(out_error_code))
    else $error("result changed while stalled");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= bps_pkg::ERR_NO_READY)
    else $error("error code out of range");

  a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ready_mask & out_blocked_mask) == '0)
    else $error("slot both ready and blocked");

  a_switch_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_request |->
      out_error_code == bps_pkg::ERR_OK && out_ready_mask[out_next_task])
    else $error("switch to a task that is not ready");

endmodule

bind bitmap_priority_task_scheduler_core bps_checker u_bps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_next_task      (out_ch.next_task),
  .out_switch_request (out_ch.switch_request),
  .out_ready_mask     (out_ch.ready_mask),
  .out_blocked_mask   (out_ch.blocked_mask),
  .out_error_code     (out_ch.error_code)
);
`default_nettype wire

// File: tb/bps_sched_checker.sv
// Scoreboard for the bitmap priority task scheduler core: predicts each result from the
// accepted input transactions and compares it field by field with the result channel.
// Depends on bps_pkg and the bps_in_if / bps_out_if interfaces.
`timescale 1ns / 100ps
module bps_sched_checker
  import bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bps_in_if          mon_in,
  bps_out_if         mon_out,
  output int         fail_count,
  output int         pending,
  output int         n_checked,
  output int         n_switches,
  output logic [7:0] err_seen
);

  logic [NUM_SLOTS-1:0]  rdy_bits  = '0;
  logic [NUM_SLOTS-1:0]  blk_bits  = '0;
  logic [NUM_SLOTS-1:0]  used_bits = '0;
  logic [DELAY_BITS-1:0] wait_cnt [NUM_SLOTS];
  logic [TOTAL_W-1:0]    n_tasks   = '0;
  logic [SLOT_W-1:0]     cur_slot  = '0;
  logic                  cur_valid = 1'b0;
  logic                  sched_on  = 1'b0;

  result_t pending_results [$];
  int      fails    = 0;
  int      checked  = 0;
  int      switches = 0;
  logic [7:0] errs  = '0;

  assign fail_count = fails;
  assign n_checked  = checked;
  assign n_switches = switches;
  assign err_seen   = errs;

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) wait_cnt[s] = '0;
  end

  function automatic logic [ERR_W-1:0] register_slot(input logic [SLOT_W-1:0] s);
    if (!sched_on) return ERR_NOT_START;
    if (n_tasks >= TOTAL_W'(NUM_SLOTS - 1)) return ERR_TOO_MANY;
    if (used_bits[s]) return ERR_TAKEN;
    used_bits[s] = 1'b1;
    rdy_bits[s]  = 1'b1;
    wait_cnt[s]  = '0;
    n_tasks      = n_tasks + 1'b1;
    return ERR_OK;
  endfunction

  function automatic logic [ERR_W-1:0] pick_lowest(output logic [SLOT_W-1:0] nxt,
                                                   output logic sw);
    nxt = cur_slot;
    sw  = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (rdy_bits[s]) begin
        sw        = !cur_valid || (cur_slot != SLOT_W'(s));
        nxt       = SLOT_W'(s);
        cur_slot  = nxt;
        cur_valid = 1'b1;
        return ERR_OK;
      end
    end
    return ERR_NO_READY;
  endfunction

  function automatic result_t schedule_event(input item_t it);
    result_t              r;
    logic [ERR_W-1:0]     err;
    logic [SLOT_W-1:0]    nxt;
    logic                 sw;
    logic [NUM_SLOTS-1:0] left;
    logic                 was_on;
    err = ERR_OK;
    nxt = cur_slot;
    sw  = 1'b0;
    case (it.func)
      FN_INIT: begin
        was_on   = sched_on;
        sched_on = 1'b1;
        err      = register_slot(IDLE_SLOT);
        if (err != ERR_OK) sched_on = was_on;
      end
      FN_ADD: err = register_slot(it.task_slot);
      FN_DELAY: begin
        if (!sched_on || !cur_valid) begin
          err = ERR_NOT_START;
        end else begin
          left = rdy_bits & ~(NUM_SLOTS'(1) << cur_slot);
          if (!left[IDLE_SLOT]) begin
            err = ERR_NO_READY;
          end else begin
            rdy_bits           = left;
            blk_bits[cur_slot] = 1'b1;
            wait_cnt[cur_slot] = it.delay_ticks;
            err                = pick_lowest(nxt, sw);
          end
        end
      end
      FN_TICK: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (blk_bits[s]) begin
            wait_cnt[s] = wait_cnt[s] - 1'b1;
            if (wait_cnt[s] == '0) begin
              rdy_bits[s] = 1'b1;
              blk_bits[s] = 1'b0;
            end
          end
        end
        err = pick_lowest(nxt, sw);
      end
      FN_RUN: err = pick_lowest(nxt, sw);
      default: ;
    endcase
    if (err != ERR_OK) begin
      nxt = cur_slot;
      sw  = 1'b0;
    end
    r.next_task      = nxt;
    r.switch_request = sw;
    r.ready_mask     = rdy_bits;
    r.blocked_mask   = blk_bits;
    r.error_code     = err;
    return r;
  endfunction

  function automatic bit field_ok(input string name, input longint unsigned want,
                                  input longint unsigned got);
    if (want == got) return 1'b1;
    $display("%0t checker: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    item_t   it;
    bit      ok;
    if (rst_n) begin
      if (mon_out.valid && mon_out.ready) begin
        got.next_task      = mon_out.next_task;
        got.switch_request = mon_out.switch_request;
        got.ready_mask     = mon_out.ready_mask;
        got.blocked_mask   = mon_out.blocked_mask;
        got.error_code     = mon_out.error_code;
        if (pending_results.size() == 0) begin
          $display("%0t checker: unexpected result, expected none, actual %0h", $time, got);
          fails++;
        end else begin
          want = pending_results.pop_front();
          ok = field_ok("next_task", want.next_task, got.next_task)
             & field_ok("switch_request", want.switch_request, got.switch_request)
             & field_ok("ready_mask", want.ready_mask, got.ready_mask)
             & field_ok("blocked_mask", want.blocked_mask, got.blocked_mask)
             & field_ok("error_code", want.error_code, got.error_code);
          if (!ok) fails++;
          checked++;
          if (want.switch_request) switches++;
          errs[want.error_code] = 1'b1;
        end
      end
      if (mon_in.valid && mon_in.ready) begin
        it.func        = mon_in.func;
        it.task_slot   = mon_in.task_slot;
        it.delay_ticks = mon_in.delay_ticks;
        pending_results.push_back(schedule_event(it));
      end
    end
    pending = pending_results.size();
  end

endmodule

// File: tb/tb.sv
// Top of the scheduler core testbench: clock, reset, directed and random event stimulus
// with random source gaps and sink stalls, and the verdict.
// Depends on bps_pkg, bps_if, the scheduler core and bps_sched_checker.
`timescale 1ns / 100ps
module tb;
  import bps_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bps_in_if  in_ch ();
  bps_out_if out_ch ();

  int         fail_count;
  int         pending;
  int         n_checked;
  int         n_switches;
  logic [7:0] err_seen;

  int   func_cnt [8];
  int   n_sched      = 0;
  int   cycles       = 0;
  int   no_idle_left = 0;
  int   snk_hold     = 0;
  logic snk_rdy      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_priority_task_scheduler_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bps_sched_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .mon_in     (in_ch),
    .mon_out    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_switches (n_switches),
    .err_seen   (err_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    int p;
    if (snk_hold > 0) begin
      snk_hold--;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 60) begin
        snk_rdy  = 1'b1;
        snk_hold = (p < 10) ? $urandom_range(20, 80) : $urandom_range(0, 12);
      end else if (p < 92) begin
        snk_rdy  = 1'b0;
        snk_hold = $urandom_range(0, 2);
      end else if (p < 97) begin
        snk_rdy  = 1'b0;
        snk_hold = $urandom_range(5, 15);
      end else begin
        snk_rdy  = 1'b0;
        snk_hold = $urandom_range(20, 40);
      end
    end
    out_ch.ready <= snk_rdy;
  end

  function automatic int src_gap();
    int p;
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 2) no_idle_left = $urandom_range(20, 80);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic send(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] slot,
                      input logic [DELAY_BITS-1:0] ticks);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= fn;
    in_ch.task_slot   <= slot;
    in_ch.delay_ticks <= ticks;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    func_cnt[fn]++;
    if (fn <= FN_RUN) n_sched++;
    @(negedge clk);
  endtask

  task automatic send_random();
    int p;
    int q;
    logic [FUNC_W-1:0]     fn;
    logic [DELAY_BITS-1:0] ticks;
    p     = $urandom_range(0, 99);
    q     = $urandom_range(0, 9);
    ticks = DELAY_BITS'($urandom);
    if (p < 2) begin
      fn = FN_INIT;
    end else if (p < 14) begin
      fn = FN_ADD;
    end else if (p < 42) begin
      fn = FN_DELAY;
      if (q < 6) ticks = DELAY_BITS'($urandom_range(1, 6));
      else if (q < 9) ticks = DELAY_BITS'($urandom_range(7, 40));
    end else if (p < 77) begin
      fn = FN_TICK;
    end else if (p < 97) begin
      fn = FN_RUN;
    end else begin
      fn = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    end
    send(fn, SLOT_W'($urandom), ticks);
  endtask

  initial begin
    int base;
    in_ch.valid       = 1'b0;
    in_ch.func        = FN_INIT;
    in_ch.task_slot   = '0;
    in_ch.delay_ticks = '0;
    out_ch.ready      = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty scheduler, not started
    send(FN_RUN,   4'd0,  16'd0);
    send(FN_TICK,  4'd0,  16'd0);
    send(FN_DELAY, 4'd0,  16'd3);
    send(FN_ADD,   4'd3,  16'd0);
    send(FN_SPARE_LO, 4'hf, 16'hffff);
    send(FN_SPARE_HI, 4'd0, 16'd0);
    // start, repeated start, taken slots
    send(FN_INIT,  4'd0,  16'd0);
    send(FN_INIT,  4'd0,  16'd0);
    send(FN_ADD,   4'd0,  16'd0);
    send(FN_ADD,   4'd0,  16'd0);
    send(FN_ADD,   IDLE_SLOT, 16'd0);
    send(FN_RUN,   4'd0,  16'd0);
    send(FN_RUN,   4'd0,  16'd0);
    // block and wake, largest and wrapping delays, idle task delay
    send(FN_DELAY, 4'd0,  16'd1);
    send(FN_TICK,  4'd0,  16'd0);
    send(FN_ADD,   4'd1,  16'd0);
    send(FN_DELAY, 4'd0,  16'hffff);
    send(FN_DELAY, 4'd0,  16'd0);
    send(FN_TICK,  4'd0,  16'd0);
    send(FN_DELAY, 4'd0,  16'd5);
    send(FN_RUN,   4'd0,  16'd0);

    base = n_sched;
    while (n_sched - base < RANDOM_ITEMS) send_random();
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: sent init %0d, add %0d, delay %0d, tick %0d, run %0d, spare codes %0d",
             func_cnt[FN_INIT], func_cnt[FN_ADD], func_cnt[FN_DELAY], func_cnt[FN_TICK],
             func_cnt[FN_RUN], func_cnt[5] + func_cnt[6] + func_cnt[7]);
    $display("tb: compared %0d results, %0d task switches, error codes seen %b",
             n_checked, n_switches, err_seen);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bps_pkg.sv
rtl/core/bps_if.sv
rtl/core/bps_prio_enc.sv
rtl/core/bps_step.sv
rtl/core/bitmap_priority_task_scheduler_core.sv
rtl/core/bps_checker.sv
tb/bps_sched_checker.sv
tb/tb.sv
